// ===== rtl/rwcp_pkg.sv =====
`default_nettype none

package rwcp_pkg;

   // Chunk tags as they gather little-endian in a 32-bit word
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   // File header byte positions
   localparam logic [31:0] POS_RIFF_TAG = 32'd3;
   localparam logic [31:0] POS_RIFF_LEN = 32'd7;
   localparam logic [31:0] POS_WAVE_TAG = 32'd11;

   // Chunk header layout
   localparam logic [32:0] CHDR_BYTES   = 33'd8;
   localparam logic [32:0] CHDR_TAG_END = 33'd4;
   localparam logic [32:0] RIFF_HDR_LEN = 33'd8;

   // Reset value of the fmt length register
   localparam logic [15:0] MIN_FMT_RESET = 16'd14;

   // Result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
   localparam logic [2:0] ST_NOT_WAVE  = 3'd2;
   localparam logic [2:0] ST_FMT_SHORT = 3'd3;
   localparam logic [2:0] ST_MISSING   = 3'd4;

   typedef enum logic [1:0] {
      PH_FILE,
      PH_CHDR,
      PH_SKIP
   } phase_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] fmt_offset;
      logic [31:0] data_offset;
      logic [31:0] data_size;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/riff_wave_chunk_parser.sv =====
// Channel   Ports                                         Direction
// req       req_valid, req_stall, req_data_byte, req_last  in (stall out)
// rsp       rsp_valid, rsp_stall, rsp_status, rsp_fmt_offset,
//           rsp_data_offset, rsp_data_size                 out (stall in)
// csr       csr_wr_en, csr_wr_data                         in
//
// One byte is taken per cycle while req_stall is low; each byte updates the
// parser state in the cycle it is accepted, and its result (if any) appears
// on rsp in the next cycle unless an earlier result still waits there.
// The output register plus one skid entry set the rate: req_stall rises only
// when both hold a result, then falls once the output drains.
// Reset is synchronous; it clears the parser, the result queue and sets
// min_fmt_length to 14.
`default_nettype none

module riff_wave_chunk_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_fmt_offset,
   output logic [31:0]      rsp_data_offset,
   output logic [31:0]      rsp_data_size,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   // Configuration
   logic [15:0] min_fmt_ff;

   // Parser state
   rwcp_pkg::phase_type phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] gather_ff, gather_in;
   logic [32:0] riff_end_ff, riff_end_in;
   logic [31:0] tag_ff, tag_in;
   logic [32:0] skip_ff, skip_in;
   logic        fmt_found_ff, fmt_found_in;
   logic [31:0] fmt_start_ff, fmt_start_in;
   logic        data_seen_ff, data_seen_in;
   logic [31:0] data_start_ff, data_start_in;
   logic [31:0] data_len_ff, data_len_in;
   logic        reported_ff, reported_in;

   // Result queue
   logic                  out_valid_ff, out_valid_in;
   rwcp_pkg::rsp_type     out_ff, out_in;
   logic                  skid_valid_ff, skid_valid_in;
   rwcp_pkg::rsp_type     skid_ff, skid_in;

   // Decode
   logic        accept;
   logic        work;
   logic [32:0] next_pos;
   logic [31:0] gather_new;
   logic [32:0] skip_dec;
   logic        at_hdr_end;
   logic        at_skip_end;
   logic        is_fmt;
   logic        is_data;
   logic        fmt_short;
   logic        hdr_emit_ok;
   logic        len_zero;
   logic [32:0] padded;
   logic        wave_ok;
   logic        go_boundary;
   logic        bnd_end;
   logic        emit;
   logic [2:0]  emit_code;
   logic        fmt_upd;
   logic        data_upd;
   logic [31:0] fmt_start_upd;
   logic [31:0] data_start_upd;
   logic [31:0] data_len_upd;
   logic        res_valid;
   rwcp_pkg::rsp_type res;
   logic        out_take;

   assign accept   = req_valid && !req_stall;
   assign work     = accept && !reported_ff;
   assign req_stall = skid_valid_ff;

   // Byte step
   assign next_pos    = {1'b0, pos_ff} + 33'd1;
   assign gather_new  = {req_data_byte, gather_ff[31:8]};
   assign skip_dec    = skip_ff - 33'd1;
   assign at_hdr_end  = (phase_ff == rwcp_pkg::PH_CHDR) && (skip_dec == 33'd0);
   assign at_skip_end = (phase_ff == rwcp_pkg::PH_SKIP) && (skip_dec == 33'd0);

   // Chunk header classification; length arrives in gather_new
   assign is_fmt      = (tag_ff == rwcp_pkg::TAG_FMT) && !fmt_found_ff;
   assign is_data     = (tag_ff == rwcp_pkg::TAG_DATA) && (!data_seen_ff || data_len_ff == 32'd0);
   assign fmt_short   = is_fmt && (gather_new < {16'd0, min_fmt_ff});
   assign hdr_emit_ok = (is_fmt && !fmt_short && data_seen_ff && data_len_ff != 32'd0)
                        || (is_data && fmt_found_ff);
   assign len_zero    = (gather_new == 32'd0);
   assign padded      = ({1'b0, gather_new} + 33'd1) & ~33'd1;
   assign wave_ok     = (gather_new == rwcp_pkg::TAG_WAVE);

   // Chunk boundary reached: end of walk or start of the next header
   assign go_boundary = ((phase_ff == rwcp_pkg::PH_FILE) && (pos_ff == rwcp_pkg::POS_WAVE_TAG)
                         && wave_ok)
                        || (at_hdr_end && !fmt_short && !hdr_emit_ok && len_zero)
                        || at_skip_end;
   assign bnd_end     = (next_pos >= riff_end_ff);

   // Result from the byte itself
   always_comb begin
      emit      = 1'b0;
      emit_code = rwcp_pkg::ST_MISSING;
      if (phase_ff == rwcp_pkg::PH_FILE && pos_ff == rwcp_pkg::POS_RIFF_TAG
          && gather_new != rwcp_pkg::TAG_RIFF) begin
         emit      = 1'b1;
         emit_code = rwcp_pkg::ST_NOT_RIFF;
      end else if (phase_ff == rwcp_pkg::PH_FILE && pos_ff == rwcp_pkg::POS_WAVE_TAG
                   && !wave_ok) begin
         emit      = 1'b1;
         emit_code = rwcp_pkg::ST_NOT_WAVE;
      end else if (go_boundary && bnd_end) begin
         emit      = 1'b1;
         emit_code = rwcp_pkg::ST_MISSING;
      end else if (at_hdr_end && fmt_short) begin
         emit      = 1'b1;
         emit_code = rwcp_pkg::ST_FMT_SHORT;
      end else if (at_hdr_end && hdr_emit_ok) begin
         emit      = 1'b1;
         emit_code = rwcp_pkg::ST_OK;
      end
   end

   // Recorded chunks after this byte
   assign fmt_upd        = at_hdr_end && is_fmt && !fmt_short;
   assign data_upd       = at_hdr_end && is_data;
   assign fmt_start_upd  = fmt_upd ? next_pos[31:0] : fmt_start_ff;
   assign data_start_upd = data_upd ? next_pos[31:0] : data_start_ff;
   assign data_len_upd   = data_upd ? gather_new : data_len_ff;

   // Build the result; a last mark without one reports the truncation
   always_comb begin
      res_valid       = work && (emit || req_last);
      res.fmt_offset  = fmt_start_upd;
      res.data_offset = data_start_upd;
      res.data_size   = data_len_upd;
      if (emit) begin
         res.status = emit_code;
      end else if (phase_ff == rwcp_pkg::PH_FILE && pos_ff < rwcp_pkg::POS_RIFF_TAG) begin
         res.status = rwcp_pkg::ST_NOT_RIFF;
      end else if (phase_ff == rwcp_pkg::PH_FILE && pos_ff < rwcp_pkg::POS_WAVE_TAG) begin
         res.status = rwcp_pkg::ST_NOT_WAVE;
      end else begin
         res.status = rwcp_pkg::ST_MISSING;
      end
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept && req_last) begin
         phase_in = rwcp_pkg::PH_FILE;
      end else if (work) begin
         if (go_boundary && !bnd_end) begin
            phase_in = rwcp_pkg::PH_CHDR;
         end else if (at_hdr_end && !emit && !len_zero) begin
            phase_in = rwcp_pkg::PH_SKIP;
         end
      end
   end

   // Datapath state
   always_comb begin
      pos_in        = pos_ff;
      gather_in     = gather_ff;
      riff_end_in   = riff_end_ff;
      tag_in        = tag_ff;
      skip_in       = skip_ff;
      fmt_found_in  = fmt_found_ff;
      fmt_start_in  = fmt_start_ff;
      data_seen_in  = data_seen_ff;
      data_start_in = data_start_ff;
      data_len_in   = data_len_ff;
      reported_in   = reported_ff;
      if (work) begin
         pos_in    = next_pos[31:0];
         gather_in = gather_new;
         case (phase_ff)
            rwcp_pkg::PH_FILE: begin
               if (pos_ff == rwcp_pkg::POS_RIFF_TAG) begin
                  tag_in = gather_new;
               end else if (pos_ff == rwcp_pkg::POS_RIFF_LEN) begin
                  riff_end_in = rwcp_pkg::RIFF_HDR_LEN + {1'b0, gather_new};
               end
            end
            rwcp_pkg::PH_CHDR: begin
               skip_in = skip_dec;
               if (skip_dec == rwcp_pkg::CHDR_TAG_END) begin
                  tag_in = gather_new;
               end else if (skip_dec == 33'd0) begin
                  skip_in = padded;
               end
            end
            rwcp_pkg::PH_SKIP: begin
               skip_in = skip_dec;
            end
            default: begin
               skip_in = skip_ff;
            end
         endcase
         if (go_boundary && !bnd_end) begin
            skip_in = rwcp_pkg::CHDR_BYTES;
         end
         fmt_found_in  = fmt_found_ff || fmt_upd;
         fmt_start_in  = fmt_start_upd;
         data_seen_in  = data_seen_ff || data_upd;
         data_start_in = data_start_upd;
         data_len_in   = data_len_upd;
         reported_in   = emit;
      end
      // Rearm on the last mark
      if (accept && req_last) begin
         pos_in        = 32'd0;
         gather_in     = 32'd0;
         riff_end_in   = 33'd0;
         tag_in        = 32'd0;
         skip_in       = 33'd0;
         fmt_found_in  = 1'b0;
         fmt_start_in  = 32'd0;
         data_seen_in  = 1'b0;
         data_start_in = 32'd0;
         data_len_in   = 32'd0;
         reported_in   = 1'b0;
      end
   end

   // Output register and skid entry
   assign out_take = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_in       = res;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_fmt_ff    <= rwcp_pkg::MIN_FMT_RESET;
         phase_ff      <= rwcp_pkg::PH_FILE;
         pos_ff        <= 32'd0;
         gather_ff     <= 32'd0;
         riff_end_ff   <= 33'd0;
         tag_ff        <= 32'd0;
         skip_ff       <= 33'd0;
         fmt_found_ff  <= 1'b0;
         fmt_start_ff  <= 32'd0;
         data_seen_ff  <= 1'b0;
         data_start_ff <= 32'd0;
         data_len_ff   <= 32'd0;
         reported_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            min_fmt_ff <= csr_wr_data;
         end
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         gather_ff     <= gather_in;
         riff_end_ff   <= riff_end_in;
         tag_ff        <= tag_in;
         skip_ff       <= skip_in;
         fmt_found_ff  <= fmt_found_in;
         fmt_start_ff  <= fmt_start_in;
         data_seen_ff  <= data_seen_in;
         data_start_ff <= data_start_in;
         data_len_ff   <= data_len_in;
         reported_ff   <= reported_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_fmt_offset  = out_ff.fmt_offset;
   assign rsp_data_offset = out_ff.data_offset;
   assign rsp_data_size   = out_ff.data_size;

`ifndef SYNTH
   // Skid entry only fills behind a held output
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> out_valid_ff)
      else $error("skid holds an item while output is empty");

   // Last mark always rearms the parser
   assert property (@(posedge clock) disable iff (reset)
                    (accept && req_last) |=> (!reported_ff && phase_ff == rwcp_pkg::PH_FILE))
      else $error("parser not rearmed after last mark");

   // Body skip never sits at zero while the walk goes on
   assert property (@(posedge clock) disable iff (reset)
                    (phase_ff == rwcp_pkg::PH_SKIP && !reported_ff) |-> (skip_ff != 33'd0))
      else $error("skip phase with zero count");

   // Header count stays within one chunk header while the walk goes on
   assert property (@(posedge clock) disable iff (reset)
                    (phase_ff == rwcp_pkg::PH_CHDR && !reported_ff)
                    |-> (skip_ff != 33'd0 && skip_ff <= rwcp_pkg::CHDR_BYTES))
      else $error("header count out of range");
`endif

endmodule

`default_nettype wire
